// File: rtl/pitb_pkg.sv
// pitb_pkg: widths and types shared by the point-in-triangle pipeline
// no dependencies; used by pitb_front, pitb_mul, pitb_decide and the top level
`default_nettype none

package pitb_pkg;

   localparam int COORD_WIDTH = 16;
   localparam int DIFF_W      = COORD_WIDTH + 1;
   localparam int ELEM_W      = 2 * DIFF_W;
   localparam int DOT_W       = ELEM_W + 2;
   localparam int HALF_W      = (DOT_W + 1) / 2;
   localparam int HI_W        = DOT_W - HALF_W;
   localparam int LL_W        = 2 * HALF_W;
   localparam int MX_W        = HALF_W + 1 + HI_W;
   localparam int HH_W        = 2 * HI_W;
   localparam int PROD_W      = 2 * DOT_W;
   localparam int RES_W       = PROD_W + 1;
   localparam int SUM_W       = RES_W + 1;
   localparam int STAGES      = 8;

   typedef logic signed [COORD_WIDTH-1:0] coord_type;
   typedef logic signed [DIFF_W-1:0]      diff_type;
   typedef logic signed [ELEM_W-1:0]      elem_type;
   typedef logic signed [DOT_W-1:0]       dot_type;
   typedef logic signed [PROD_W-1:0]      prod_type;
   typedef logic signed [RES_W-1:0]       res_type;
   typedef logic signed [SUM_W-1:0]       sum_type;

   typedef struct packed {
      logic signed [DOT_W-1:0] uu;
      logic signed [DOT_W-1:0] uv;
      logic signed [DOT_W-1:0] vv;
      logic signed [DOT_W-1:0] wu;
      logic signed [DOT_W-1:0] wv;
   } dots_type;

   typedef struct packed {
      logic signed [PROD_W-1:0] uv_uv;
      logic signed [PROD_W-1:0] uu_vv;
      logic signed [PROD_W-1:0] uv_wv;
      logic signed [PROD_W-1:0] vv_wu;
      logic signed [PROD_W-1:0] uv_wu;
      logic signed [PROD_W-1:0] uu_wv;
   } prods_type;

endpackage

`default_nettype wire

// File: rtl/pitb_front.sv
// pitb_front: edge vectors, per-axis products and the five dot products
// three register stages; depends on pitb_pkg
`default_nettype none

module pitb_front (
   input  wire logic                clock,
   input  wire logic [2:0]          load,
   input  wire pitb_pkg::coord_type point    [3],
   input  wire pitb_pkg::coord_type corner_a [3],
   input  wire pitb_pkg::coord_type corner_b [3],
   input  wire pitb_pkg::coord_type corner_c [3],
   output pitb_pkg::dots_type       dots
);

   pitb_pkg::diff_type u_ff [3];
   pitb_pkg::diff_type v_ff [3];
   pitb_pkg::diff_type w_ff [3];
   pitb_pkg::diff_type u_in [3];
   pitb_pkg::diff_type v_in [3];
   pitb_pkg::diff_type w_in [3];

   pitb_pkg::elem_type uu_ff [3];
   pitb_pkg::elem_type uv_ff [3];
   pitb_pkg::elem_type vv_ff [3];
   pitb_pkg::elem_type wu_ff [3];
   pitb_pkg::elem_type wv_ff [3];
   pitb_pkg::elem_type uu_in [3];
   pitb_pkg::elem_type uv_in [3];
   pitb_pkg::elem_type vv_in [3];
   pitb_pkg::elem_type wu_in [3];
   pitb_pkg::elem_type wv_in [3];

   pitb_pkg::dots_type dots_ff;
   pitb_pkg::dots_type dots_in;

   function automatic pitb_pkg::dot_type sum3(input pitb_pkg::elem_type e [3]);
      return pitb_pkg::dot_type'(e[0]) + pitb_pkg::dot_type'(e[1])
           + pitb_pkg::dot_type'(e[2]);
   endfunction

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         u_in[i] = pitb_pkg::diff_type'(corner_b[i]) - pitb_pkg::diff_type'(corner_a[i]);
         v_in[i] = pitb_pkg::diff_type'(corner_c[i]) - pitb_pkg::diff_type'(corner_a[i]);
         w_in[i] = pitb_pkg::diff_type'(point[i]) - pitb_pkg::diff_type'(corner_a[i]);
         uu_in[i] = pitb_pkg::elem_type'(u_ff[i]) * pitb_pkg::elem_type'(u_ff[i]);
         uv_in[i] = pitb_pkg::elem_type'(u_ff[i]) * pitb_pkg::elem_type'(v_ff[i]);
         vv_in[i] = pitb_pkg::elem_type'(v_ff[i]) * pitb_pkg::elem_type'(v_ff[i]);
         wu_in[i] = pitb_pkg::elem_type'(w_ff[i]) * pitb_pkg::elem_type'(u_ff[i]);
         wv_in[i] = pitb_pkg::elem_type'(w_ff[i]) * pitb_pkg::elem_type'(v_ff[i]);
      end
      dots_in.uu = sum3(uu_ff);
      dots_in.uv = sum3(uv_ff);
      dots_in.vv = sum3(vv_ff);
      dots_in.wu = sum3(wu_ff);
      dots_in.wv = sum3(wv_ff);
   end

   always_ff @(posedge clock) begin
      if (load[0]) begin
         u_ff <= u_in;
         v_ff <= v_in;
         w_ff <= w_in;
      end
      if (load[1]) begin
         uu_ff <= uu_in;
         uv_ff <= uv_in;
         vv_ff <= vv_in;
         wu_ff <= wu_in;
         wv_ff <= wv_in;
      end
      if (load[2]) begin
         dots_ff <= dots_in;
      end
   end

   assign dots = dots_ff;

endmodule

`default_nettype wire

// File: rtl/pitb_mul.sv
// pitb_mul: signed multiply of two dot products split into four half-width
// partial products, then recombined; two register stages; depends on pitb_pkg
`default_nettype none

module pitb_mul (
   input  wire logic              clock,
   input  wire logic [1:0]        load,
   input  wire pitb_pkg::dot_type a,
   input  wire pitb_pkg::dot_type b,
   output pitb_pkg::prod_type     product
);

   logic        [pitb_pkg::HALF_W-1:0] a_lo;
   logic        [pitb_pkg::HALF_W-1:0] b_lo;
   logic signed [pitb_pkg::HI_W-1:0]   a_hi;
   logic signed [pitb_pkg::HI_W-1:0]   b_hi;

   logic        [pitb_pkg::LL_W-1:0] ll_ff, ll_in;
   logic signed [pitb_pkg::MX_W-1:0] lh_ff, lh_in;
   logic signed [pitb_pkg::MX_W-1:0] hl_ff, hl_in;
   logic signed [pitb_pkg::HH_W-1:0] hh_ff, hh_in;

   pitb_pkg::prod_type prod_ff, prod_in;

   always_comb begin
      a_lo  = a[pitb_pkg::HALF_W-1:0];
      b_lo  = b[pitb_pkg::HALF_W-1:0];
      a_hi  = a[pitb_pkg::DOT_W-1:pitb_pkg::HALF_W];
      b_hi  = b[pitb_pkg::DOT_W-1:pitb_pkg::HALF_W];
      ll_in = {{pitb_pkg::HALF_W{1'b0}}, a_lo} * {{pitb_pkg::HALF_W{1'b0}}, b_lo};
      lh_in = $signed({{(pitb_pkg::MX_W - pitb_pkg::HALF_W){1'b0}}, a_lo})
            * $signed({{(pitb_pkg::MX_W - pitb_pkg::HI_W){b_hi[pitb_pkg::HI_W-1]}}, b_hi});
      hl_in = $signed({{(pitb_pkg::MX_W - pitb_pkg::HI_W){a_hi[pitb_pkg::HI_W-1]}}, a_hi})
            * $signed({{(pitb_pkg::MX_W - pitb_pkg::HALF_W){1'b0}}, b_lo});
      hh_in = $signed({{pitb_pkg::HI_W{a_hi[pitb_pkg::HI_W-1]}}, a_hi})
            * $signed({{pitb_pkg::HI_W{b_hi[pitb_pkg::HI_W-1]}}, b_hi});
      prod_in = (pitb_pkg::prod_type'(hh_ff) <<< (2 * pitb_pkg::HALF_W))
              + ((pitb_pkg::prod_type'(lh_ff) + pitb_pkg::prod_type'(hl_ff))
                 <<< pitb_pkg::HALF_W)
              + pitb_pkg::prod_type'({{(pitb_pkg::PROD_W - pitb_pkg::LL_W){1'b0}}, ll_ff});
   end

   always_ff @(posedge clock) begin
      if (load[0]) begin
         ll_ff <= ll_in;
         lh_ff <= lh_in;
         hl_ff <= hl_in;
         hh_ff <= hh_in;
      end
      if (load[1]) begin
         prod_ff <= prod_in;
      end
   end

   assign product = prod_ff;

endmodule

`default_nettype wire

// File: rtl/pitb_decide.sv
// pitb_decide: denominator and numerators, then sign tests against the
// denominator; three register stages; depends on pitb_pkg
`default_nettype none

module pitb_decide (
   input  wire logic                clock,
   input  wire logic [2:0]          load,
   input  wire pitb_pkg::prods_type prods,
   output logic                     inside_res,
   output logic                     degenerate
);

   pitb_pkg::res_type denom_ff, denom_in;
   pitb_pkg::res_type sn_ff, sn_in;
   pitb_pkg::res_type tn_ff, tn_in;

   pitb_pkg::sum_type sum_ff, sum_in;
   pitb_pkg::sum_type dsum_ff, dsum_in;
   logic d_zero_ff, d_zero_in;
   logic d_neg_ff, d_neg_in;
   logic sn_neg_ff, sn_neg_in;
   logic sn_zero_ff, sn_zero_in;
   logic tn_neg_ff, tn_neg_in;
   logic tn_zero_ff, tn_zero_in;

   logic inside_ff, inside_in;
   logic degen_ff, degen_in;
   logic s_ok, t_ok, sum_ok;

   always_comb begin
      denom_in = pitb_pkg::res_type'(prods.uv_uv) - pitb_pkg::res_type'(prods.uu_vv);
      sn_in    = pitb_pkg::res_type'(prods.uv_wv) - pitb_pkg::res_type'(prods.vv_wu);
      tn_in    = pitb_pkg::res_type'(prods.uv_wu) - pitb_pkg::res_type'(prods.uu_wv);

      sum_in     = pitb_pkg::sum_type'(sn_ff) + pitb_pkg::sum_type'(tn_ff);
      dsum_in    = pitb_pkg::sum_type'(denom_ff);
      d_zero_in  = (denom_ff == '0);
      d_neg_in   = denom_ff[pitb_pkg::RES_W-1];
      sn_neg_in  = sn_ff[pitb_pkg::RES_W-1];
      sn_zero_in = (sn_ff == '0);
      tn_neg_in  = tn_ff[pitb_pkg::RES_W-1];
      tn_zero_in = (tn_ff == '0);

      // negative denominator flips every comparison
      if (d_neg_ff) begin
         s_ok   = sn_neg_ff || sn_zero_ff;
         t_ok   = tn_neg_ff || tn_zero_ff;
         sum_ok = (sum_ff >= dsum_ff);
      end else begin
         s_ok   = !sn_neg_ff;
         t_ok   = !tn_neg_ff;
         sum_ok = (sum_ff <= dsum_ff);
      end
      degen_in  = d_zero_ff;
      inside_in = !d_zero_ff && s_ok && t_ok && sum_ok;
   end

   always_ff @(posedge clock) begin
      if (load[0]) begin
         denom_ff <= denom_in;
         sn_ff    <= sn_in;
         tn_ff    <= tn_in;
      end
      if (load[1]) begin
         sum_ff     <= sum_in;
         dsum_ff    <= dsum_in;
         d_zero_ff  <= d_zero_in;
         d_neg_ff   <= d_neg_in;
         sn_neg_ff  <= sn_neg_in;
         sn_zero_ff <= sn_zero_in;
         tn_neg_ff  <= tn_neg_in;
         tn_zero_ff <= tn_zero_in;
      end
      if (load[2]) begin
         inside_ff <= inside_in;
         degen_ff  <= degen_in;
      end
   end

   assign inside_res = inside_ff;
   assign degenerate = degen_ff;

endmodule

`default_nettype wire

// File: rtl/point_in_triangle_barycentric_unit.sv
// point_in_triangle_barycentric_unit: 3d barycentric point-in-triangle test
// one response beat per accepted request beat, in order; one beat per cycle while rsp_stall is low
// eight pipeline stages: differences, axis products, dot sums, two multiply stages,
// numerators, sum, compare; any stage holding a bubble keeps accepting upstream
// synchronous reset clears the stage valid bits only; depends on pitb_pkg,
// pitb_front, pitb_mul and pitb_decide
`default_nettype none

module point_in_triangle_barycentric_unit (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_stall,
   input  wire pitb_pkg::coord_type req_point_x,
   input  wire pitb_pkg::coord_type req_point_y,
   input  wire pitb_pkg::coord_type req_point_z,
   input  wire pitb_pkg::coord_type req_corner_a_x,
   input  wire pitb_pkg::coord_type req_corner_a_y,
   input  wire pitb_pkg::coord_type req_corner_a_z,
   input  wire pitb_pkg::coord_type req_corner_b_x,
   input  wire pitb_pkg::coord_type req_corner_b_y,
   input  wire pitb_pkg::coord_type req_corner_b_z,
   input  wire pitb_pkg::coord_type req_corner_c_x,
   input  wire pitb_pkg::coord_type req_corner_c_y,
   input  wire pitb_pkg::coord_type req_corner_c_z,
   output logic                     rsp_valid,
   input  wire logic                rsp_stall,
   output logic                     rsp_inside_res,
   output logic                     rsp_degenerate
);

   logic [pitb_pkg::STAGES-1:0] v_ff, v_in;
   logic [pitb_pkg::STAGES-1:0] load;

   pitb_pkg::coord_type point    [3];
   pitb_pkg::coord_type corner_a [3];
   pitb_pkg::coord_type corner_b [3];
   pitb_pkg::coord_type corner_c [3];
   pitb_pkg::dots_type  dots;
   pitb_pkg::prods_type prods;

   assign point    = '{req_point_x, req_point_y, req_point_z};
   assign corner_a = '{req_corner_a_x, req_corner_a_y, req_corner_a_z};
   assign corner_b = '{req_corner_b_x, req_corner_b_y, req_corner_b_z};
   assign corner_c = '{req_corner_c_x, req_corner_c_y, req_corner_c_z};

   // a stage loads when empty or when the stage after it moves
   always_comb begin
      load[pitb_pkg::STAGES-1] = !v_ff[pitb_pkg::STAGES-1] || !rsp_stall;
      for (int k = pitb_pkg::STAGES - 2; k >= 0; k--) begin
         load[k] = !v_ff[k] || load[k+1];
      end
      v_in[0] = load[0] ? req_valid : v_ff[0];
      for (int k = 1; k < pitb_pkg::STAGES; k++) begin
         v_in[k] = load[k] ? v_ff[k-1] : v_ff[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         v_ff <= v_in;
      end
   end

   assign req_stall = !load[0];
   assign rsp_valid = v_ff[pitb_pkg::STAGES-1];

   pitb_front u_front (
      .clock    (clock),
      .load     (load[2:0]),
      .point    (point),
      .corner_a (corner_a),
      .corner_b (corner_b),
      .corner_c (corner_c),
      .dots     (dots)
   );

   pitb_mul u_mul_uv_uv (
      .clock (clock), .load (load[4:3]), .a (dots.uv), .b (dots.uv), .product (prods.uv_uv)
   );
   pitb_mul u_mul_uu_vv (
      .clock (clock), .load (load[4:3]), .a (dots.uu), .b (dots.vv), .product (prods.uu_vv)
   );
   pitb_mul u_mul_uv_wv (
      .clock (clock), .load (load[4:3]), .a (dots.uv), .b (dots.wv), .product (prods.uv_wv)
   );
   pitb_mul u_mul_vv_wu (
      .clock (clock), .load (load[4:3]), .a (dots.vv), .b (dots.wu), .product (prods.vv_wu)
   );
   pitb_mul u_mul_uv_wu (
      .clock (clock), .load (load[4:3]), .a (dots.uv), .b (dots.wu), .product (prods.uv_wu)
   );
   pitb_mul u_mul_uu_wv (
      .clock (clock), .load (load[4:3]), .a (dots.uu), .b (dots.wv), .product (prods.uu_wv)
   );

   pitb_decide u_decide (
      .clock      (clock),
      .load       (load[7:5]),
      .prods      (prods),
      .inside_res (rsp_inside_res),
      .degenerate (rsp_degenerate)
   );

`ifndef SYNTHESIS
   // input side only stalls when every stage is full and the output is held
   a_stall_only_when_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> ((&v_ff) && rsp_stall))
      else $error("request stalled with a bubble in the pipeline");

   // beats in flight only drop by a response beat
   a_no_lost_beat: assert property (@(posedge clock) disable iff (reset)
      !(rsp_valid && !rsp_stall) |=> ($countones(v_ff) >= $past($countones(v_ff))))
      else $error("beat lost inside the pipeline");

   // an empty stage before the output leaves the output empty after a beat
   a_no_repeat_beat: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_stall && !v_ff[pitb_pkg::STAGES-2]) |=> !rsp_valid)
      else $error("response beat repeated");
`endif

endmodule

`default_nettype wire

// File: dv/pitb_inside_checker.sv
// pitb_inside_checker: watches the request and response channels of the point-in-triangle
// unit, predicts inside_res and degenerate for every accepted request beat and compares
// them in order; depends on pitb_pkg for the coordinate type
module pitb_inside_checker (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   input  wire logic                req_stall,
   input  wire pitb_pkg::coord_type req_point_x,
   input  wire pitb_pkg::coord_type req_point_y,
   input  wire pitb_pkg::coord_type req_point_z,
   input  wire pitb_pkg::coord_type req_corner_a_x,
   input  wire pitb_pkg::coord_type req_corner_a_y,
   input  wire pitb_pkg::coord_type req_corner_a_z,
   input  wire pitb_pkg::coord_type req_corner_b_x,
   input  wire pitb_pkg::coord_type req_corner_b_y,
   input  wire pitb_pkg::coord_type req_corner_b_z,
   input  wire pitb_pkg::coord_type req_corner_c_x,
   input  wire pitb_pkg::coord_type req_corner_c_y,
   input  wire pitb_pkg::coord_type req_corner_c_z,
   input  wire logic                rsp_valid,
   input  wire logic                rsp_stall,
   input  wire logic                rsp_inside_res,
   input  wire logic                rsp_degenerate,
   output int                       mismatches,
   output int                       awaiting
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef logic signed [2:0][pitb_pkg::COORD_WIDTH-1:0] vec3_type;
   typedef logic signed [127:0] wide_type;

   typedef struct packed {
      logic in_tri;
      logic degenerate;
   } verdict_type;

   verdict_type verdict_q[$];

   function automatic verdict_type classify_point(input vec3_type pt, input vec3_type ca,
                                                  input vec3_type cb, input vec3_type cc);
      longint eu, ev, ew;
      longint uu, uv, vv, wu, wv;
      wide_type denom, sn, tn;
      verdict_type v;
      uu = 0;
      uv = 0;
      vv = 0;
      wu = 0;
      wv = 0;
      for (int i = 0; i < 3; i++) begin
         eu = longint'(pitb_pkg::coord_type'(cb[i])) - longint'(pitb_pkg::coord_type'(ca[i]));
         ev = longint'(pitb_pkg::coord_type'(cc[i])) - longint'(pitb_pkg::coord_type'(ca[i]));
         ew = longint'(pitb_pkg::coord_type'(pt[i])) - longint'(pitb_pkg::coord_type'(ca[i]));
         uu += eu * eu;
         uv += eu * ev;
         vv += ev * ev;
         wu += ew * eu;
         wv += ew * ev;
      end
      denom = wide_type'(uv) * wide_type'(uv) - wide_type'(uu) * wide_type'(vv);
      v.in_tri = 1'b0;
      v.degenerate = 1'b0;
      if (denom == 0) begin
         v.degenerate = 1'b1;
      end else begin
         sn = wide_type'(uv) * wide_type'(wv) - wide_type'(vv) * wide_type'(wu);
         tn = wide_type'(uv) * wide_type'(wu) - wide_type'(uu) * wide_type'(wv);
         // fold the sign of denom into the numerators
         if (denom < 0) begin
            denom = -denom;
            sn = -sn;
            tn = -tn;
         end
         v.in_tri = (sn >= 0) && (tn >= 0) && (sn + tn <= denom);
      end
      return v;
   endfunction

   always @(posedge clock) begin : watch
      verdict_type want;
      if (reset) begin
         verdict_q.delete();
      end else begin
         if (req_valid && !req_stall) begin
            verdict_q.push_back(classify_point(
               {req_point_z, req_point_y, req_point_x},
               {req_corner_a_z, req_corner_a_y, req_corner_a_x},
               {req_corner_b_z, req_corner_b_y, req_corner_b_x},
               {req_corner_c_z, req_corner_c_y, req_corner_c_x}));
         end
         if (rsp_valid && !rsp_stall) begin
            if (verdict_q.size() == 0) begin
               $error("response beat with no request outstanding");
               mismatches++;
            end else begin
               want = verdict_q.pop_front();
               if (rsp_inside_res !== want.in_tri) begin
                  $error("inside_res: expected %0b, actual %0b", want.in_tri, rsp_inside_res);
                  mismatches++;
               end
               if (rsp_degenerate !== want.degenerate) begin
                  $error("degenerate: expected %0b, actual %0b",
                         want.degenerate, rsp_degenerate);
                  mismatches++;
               end
            end
         end
      end
      awaiting <= verdict_q.size();
   end

endmodule

// File: dv/tb_point_in_triangle_barycentric_unit.sv
// tb_point_in_triangle_barycentric_unit: drives directed and random triangle queries into
// the point-in-triangle unit under varying idle and stall patterns and gives the verdict;
// depends on pitb_pkg, the unit and pitb_inside_checker
module tb_point_in_triangle_barycentric_unit;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT = 400000;
   localparam int RANDOM_PER_PHASE = 200;

   typedef logic signed [2:0][pitb_pkg::COORD_WIDTH-1:0] vec3_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_stall;
   pitb_pkg::coord_type req_point_x = '0;
   pitb_pkg::coord_type req_point_y = '0;
   pitb_pkg::coord_type req_point_z = '0;
   pitb_pkg::coord_type req_corner_a_x = '0;
   pitb_pkg::coord_type req_corner_a_y = '0;
   pitb_pkg::coord_type req_corner_a_z = '0;
   pitb_pkg::coord_type req_corner_b_x = '0;
   pitb_pkg::coord_type req_corner_b_y = '0;
   pitb_pkg::coord_type req_corner_b_z = '0;
   pitb_pkg::coord_type req_corner_c_x = '0;
   pitb_pkg::coord_type req_corner_c_y = '0;
   pitb_pkg::coord_type req_corner_c_z = '0;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   logic                rsp_inside_res;
   logic                rsp_degenerate;

   int fail_count;
   int awaiting;
   int send_idle_pct = 0;
   int rsp_stall_pct = 0;
   int hold_left = 0;
   int cycle_count = 0;

   point_in_triangle_barycentric_unit DUT (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_point_x   (req_point_x),
      .req_point_y   (req_point_y),
      .req_point_z   (req_point_z),
      .req_corner_a_x(req_corner_a_x),
      .req_corner_a_y(req_corner_a_y),
      .req_corner_a_z(req_corner_a_z),
      .req_corner_b_x(req_corner_b_x),
      .req_corner_b_y(req_corner_b_y),
      .req_corner_b_z(req_corner_b_z),
      .req_corner_c_x(req_corner_c_x),
      .req_corner_c_y(req_corner_c_y),
      .req_corner_c_z(req_corner_c_z),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_inside_res(rsp_inside_res),
      .rsp_degenerate(rsp_degenerate)
   );

   pitb_inside_checker checker_i (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_point_x   (req_point_x),
      .req_point_y   (req_point_y),
      .req_point_z   (req_point_z),
      .req_corner_a_x(req_corner_a_x),
      .req_corner_a_y(req_corner_a_y),
      .req_corner_a_z(req_corner_a_z),
      .req_corner_b_x(req_corner_b_x),
      .req_corner_b_y(req_corner_b_y),
      .req_corner_b_z(req_corner_b_z),
      .req_corner_c_x(req_corner_c_x),
      .req_corner_c_y(req_corner_c_y),
      .req_corner_c_z(req_corner_c_z),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_inside_res(rsp_inside_res),
      .rsp_degenerate(rsp_degenerate),
      .mismatches    (fail_count),
      .awaiting      (awaiting)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // receiver: a long hold-off when requested, otherwise random stalls
   initial begin
      forever begin
         @(posedge clock);
         if (hold_left > 0) begin
            rsp_stall <= 1'b1;
            hold_left--;
         end else begin
            rsp_stall <= (int'($urandom_range(99)) < rsp_stall_pct);
         end
      end
   end

   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("*** FAILED ***");
      $finish;
   end

   function automatic int clamp16(input int x);
      if (x > 32767) return 32767;
      if (x < -32768) return -32768;
      return x;
   endfunction

   function automatic int spread(input int r);
      return int'($urandom_range(2 * r)) - r;
   endfunction

   function automatic vec3_type make_vec(input int x, input int y, input int z);
      vec3_type v;
      v[0] = pitb_pkg::coord_type'(clamp16(x));
      v[1] = pitb_pkg::coord_type'(clamp16(y));
      v[2] = pitb_pkg::coord_type'(clamp16(z));
      return v;
   endfunction

   function automatic int pick_extreme();
      case ($urandom_range(6))
         0: return -32768;
         1: return -32767;
         2: return -1;
         3: return 0;
         4: return 1;
         5: return 32766;
         default: return 32767;
      endcase
   endfunction

   task automatic send_query(input vec3_type pt, input vec3_type ca, input vec3_type cb,
                             input vec3_type cc);
      while (int'($urandom_range(99)) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_point_x    <= pt[0];
      req_point_y    <= pt[1];
      req_point_z    <= pt[2];
      req_corner_a_x <= ca[0];
      req_corner_a_y <= ca[1];
      req_corner_a_z <= ca[2];
      req_corner_b_x <= cb[0];
      req_corner_b_y <= cb[1];
      req_corner_b_z <= cb[2];
      req_corner_c_x <= cc[0];
      req_corner_c_y <= cc[1];
      req_corner_c_z <= cc[2];
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task automatic send_random_query();
      int ax, ay, az, ux, uy, uz, vx, vy, vz, i, j, k;
      vec3_type pt, ca, cb, cc;
      case ($urandom_range(9))
         0, 1: begin
            pt = vec3_type'({$urandom, $urandom});
            ca = vec3_type'({$urandom, $urandom});
            cb = vec3_type'({$urandom, $urandom});
            cc = vec3_type'({$urandom, $urandom});
         end
         2, 3, 4, 5: begin
            // point built from the edge vectors, near or on the triangle, at times far off its plane
            ax = spread(4000); ay = spread(4000); az = spread(4000);
            ux = spread(2000); uy = spread(2000); uz = spread(2000);
            vx = spread(2000); vy = spread(2000); vz = spread(2000);
            i = int'($urandom_range(12)) - 2;
            j = int'($urandom_range(12)) - 2;
            k = ($urandom_range(3) == 0) ? spread(20000) : spread(64);
            ca = make_vec(ax, ay, az);
            cb = make_vec(ax + ux, ay + uy, az + uz);
            cc = make_vec(ax + vx, ay + vy, az + vz);
            pt = make_vec(ax + (i * ux + j * vx) / 8, ay + (i * uy + j * vy) / 8,
                          az + (i * uz + j * vz) / 8 + k);
         end
         6, 7: begin
            ax = spread(32000); ay = spread(32000); az = spread(32000);
            ca = make_vec(ax + spread(300), ay + spread(300), az + spread(300));
            cb = make_vec(ax + spread(300), ay + spread(300), az + spread(300));
            cc = make_vec(ax + spread(300), ay + spread(300), az + spread(300));
            pt = make_vec(ax + spread(300), ay + spread(300), az + spread(300));
         end
         8: begin
            // collinear or coincident corners
            ax = spread(10000); ay = spread(10000); az = spread(10000);
            ux = spread(3000); uy = spread(3000); uz = spread(3000);
            k = int'($urandom_range(6)) - 3;
            ca = make_vec(ax, ay, az);
            cb = make_vec(ax + ux, ay + uy, az + uz);
            cc = make_vec(ax + k * ux, ay + k * uy, az + k * uz);
            pt = make_vec(spread(32767), spread(32767), spread(32767));
         end
         default: begin
            pt = make_vec(pick_extreme(), pick_extreme(), pick_extreme());
            ca = make_vec(pick_extreme(), pick_extreme(), pick_extreme());
            cb = make_vec(pick_extreme(), pick_extreme(), pick_extreme());
            cc = make_vec(pick_extreme(), pick_extreme(), pick_extreme());
         end
      endcase
      send_query(pt, ca, cb, cc);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (awaiting != 0) @(posedge clock);
   endtask

   initial begin
      int idle_set[4];
      int stall_set[4];
      vec3_type o, ex, ey;
      idle_set  = '{0, 87, 0, 7};
      stall_set = '{0, 0, 87, 7};
      o  = make_vec(0, 0, 0);
      ex = make_vec(256, 0, 0);
      ey = make_vec(0, 256, 0);

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // degenerate: all zero, all max, all min
      send_query(o, o, o, o);
      send_query(make_vec(32767, 32767, 32767), make_vec(32767, 32767, 32767),
                 make_vec(32767, 32767, 32767), make_vec(32767, 32767, 32767));
      send_query(make_vec(-32768, -32768, -32768), make_vec(-32768, -32768, -32768),
                 make_vec(-32768, -32768, -32768), make_vec(-32768, -32768, -32768));
      // unit triangle in the xy plane: interior, corners, hypotenuse, just outside
      send_query(make_vec(64, 64, 0), o, ex, ey);
      send_query(o, o, ex, ey);
      send_query(ex, o, ex, ey);
      send_query(ey, o, ex, ey);
      send_query(make_vec(128, 128, 0), o, ex, ey);
      send_query(make_vec(129, 128, 0), o, ex, ey);
      send_query(make_vec(-1, 0, 0), o, ex, ey);
      send_query(make_vec(0, -1, 0), o, ex, ey);
      send_query(make_vec(128, 0, 0), o, ex, ey);
      // far off the plane, projection inside
      send_query(make_vec(64, 64, 32767), o, ex, ey);
      send_query(make_vec(64, 64, -32768), o, ey, ex);
      // collinear and coincident corners
      send_query(make_vec(5, 7, 9), o, make_vec(100, 100, 100), make_vec(200, 200, 200));
      send_query(make_vec(5, 7, 9), ex, ex, ey);
      send_query(make_vec(5, 7, 9), o, ex, o);
      // full-range triangles
      send_query(make_vec(0, 0, 32767), make_vec(-32768, -32768, -32768),
                 make_vec(32767, -32768, -32768), make_vec(-32768, 32767, -32768));
      send_query(make_vec(32767, 32767, 32767), make_vec(-32768, -32768, -32768),
                 make_vec(32767, -32768, -32768), make_vec(-32768, 32767, -32768));
      send_query(make_vec(-32768, 32767, -32768), make_vec(32767, 32767, 32767),
                 make_vec(-32768, -32768, 32767), make_vec(32767, -32768, -32768));
      // triangles in the yz and xz planes
      send_query(make_vec(-500, 50, 50), make_vec(0, 0, 0), make_vec(0, 256, 0),
                 make_vec(0, 0, 256));
      send_query(make_vec(30, 900, 300), make_vec(0, 0, 0), make_vec(256, 0, 0),
                 make_vec(0, 0, 256));
      // alternating bit patterns
      send_query(make_vec(21845, -21846, 21845), make_vec(-21846, 21845, -21846),
                 make_vec(21845, 21845, -21846), make_vec(-21846, -21846, 21845));
      drain();

      for (int ph = 0; ph < 4; ph++) begin
         send_idle_pct = idle_set[ph];
         rsp_stall_pct = stall_set[ph];
         // long receiver hold-off so the pipeline fills and backs up
         if (ph == 0) hold_left = 300;
         for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
            send_random_query();
         end
         drain();
      end

      repeat (pitb_pkg::STAGES + 12) @(posedge clock);
      if (fail_count == 0 && awaiting == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
